FILE: rtl/pcag_pkg.sv
package pcag_pkg;

  localparam int ROWS = 128;
  localparam int COLS = 64;

  localparam int ROW_IN_W = 7;
  localparam int COL_IN_W = 6;

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  // sweep counter must reach ROWS + 1
  localparam int CNT_W = $clog2(ROWS + 2);

  localparam int CENTER_ROW = ROWS / 2;
  localparam int CENTER_COL = COLS / 2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_TICK,
    ST_DONE
  } state_t;

  typedef logic [COLS-1:0] row_word_t;

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    row_word_t        wr_data;
  } mem_req_t;

  typedef struct packed {
    logic       load;
    logic       cell_bit;
    logic [1:0] kind;
  } res_t;

endpackage

FILE: rtl/parity_cellular_automaton_grid_top.sv
// channel | signals                            | direction
// input   | in_valid/in_ready, operation, row, | in
//         | column, cell_in                    |
// output  | out_valid/out_ready, cell_value,   | out
//         | done_kind                          |
//
// After reset a clearing pass writes all ROWS (128) rows of the initial grid;
// no transaction is taken meanwhile.
// Read/write: row read from the grid memory, then modify/write back.
// Tick: ROWS + 2 sweep steps, then the result; one row word per cycle through a
// three-row window on the single read and single write port of the memory.
// Invalid ops go straight to the result (row and column widths always fit the grid).
// A stalled output holds the engine in its final state; one new transaction
// may be accepted while a result waits.
module parity_cellular_automaton_grid_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [pcag_pkg::ROW_IN_W-1:0] row,
  input  logic [pcag_pkg::COL_IN_W-1:0] column,
  input  logic                          cell_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          cell_value,
  output logic [1:0]                    done_kind
);
  import pcag_pkg::*;

  mem_req_t  req;
  row_word_t rd_data;
  res_t      res;
  logic      out_free;

  assign out_free = !out_valid || out_ready;

  pcag_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  pcag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .operation(operation),
    .row      (row),
    .column   (column),
    .cell_in  (cell_in),
    .out_free (out_free),
    .rd_data  (rd_data),
    .req      (req),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      cell_value <= res.cell_bit;
      done_kind  <= res.kind;
    end
  end

endmodule

FILE: rtl/pcag_mem.sv
module pcag_mem (
  input  logic                clk,
  input  pcag_pkg::mem_req_t  req,
  output pcag_pkg::row_word_t rd_data
);
  import pcag_pkg::*;

  row_word_t mem [ROWS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: rtl/pcag_ctrl.sv
module pcag_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [pcag_pkg::ROW_IN_W-1:0] row,
  input  logic [pcag_pkg::COL_IN_W-1:0] column,
  input  logic                          cell_in,
  input  logic                          out_free,
  input  pcag_pkg::row_word_t           rd_data,
  output pcag_pkg::mem_req_t            req,
  output pcag_pkg::res_t                res
);
  import pcag_pkg::*;

  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [1:0]          op_q, op_q_next;
  logic [ROW_W-1:0]    row_q, row_q_next;
  logic [COL_W-1:0]    col_q, col_q_next;
  logic                val_q, val_q_next;
  row_word_t           above, above_next;
  row_word_t           cur, cur_next;

  row_word_t           below;
  row_word_t           bit_mask;
  logic                in_grid;
  logic [CNT_W-1:0]    wr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q  <= op_q_next;
    row_q <= row_q_next;
    col_q <= col_q_next;
    val_q <= val_q_next;
    above <= above_next;
    cur   <= cur_next;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    op_q_next  = op_q;
    row_q_next = row_q;
    col_q_next = col_q;
    val_q_next = val_q;
    above_next = above;
    cur_next   = cur;
    in_ready   = 1'b0;
    req        = '0;
    res        = '0;
    res.kind   = op_q;
    below      = '0;
    bit_mask   = row_word_t'(1) << col_q;
    wr_cnt     = cnt - CNT_W'(2);
    in_grid    = (32'(row) < 32'(ROWS)) && (32'(column) < 32'(COLS));

    unique case (state)
      ST_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = cnt[ROW_W-1:0];
        req.wr_data = (cnt == CNT_W'(CENTER_ROW)) ? (row_word_t'(1) << CENTER_COL) : '0;
        if (cnt == CNT_W'(ROWS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_q_next  = operation;
          row_q_next = ROW_W'(row);
          col_q_next = COL_W'(column);
          val_q_next = cell_in;
          if (operation == OP_TICK) begin
            cnt_next   = '0;
            above_next = '0;
            cur_next   = '0;
            state_next = ST_TICK;
          end else if ((operation == OP_WRITE || operation == OP_READ) && in_grid) begin
            req.rd_en   = 1'b1;
            req.rd_addr = ROW_W'(row);
            state_next  = ST_CELL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end

      ST_CELL: begin
        // read data holds here until the result slot frees up
        if (out_free) begin
          res.load = 1'b1;
          if (op_q == OP_WRITE) begin
            res.cell_bit = val_q;
            req.wr_en    = 1'b1;
            req.wr_addr  = row_q;
            req.wr_data  = val_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
          end else begin
            res.cell_bit = rd_data[col_q];
          end
          state_next = ST_IDLE;
        end
      end

      ST_TICK: begin
        // read row cnt; row cnt-1 arrives; new row cnt-2 is written
        if (cnt < CNT_W'(ROWS)) begin
          req.rd_en   = 1'b1;
          req.rd_addr = cnt[ROW_W-1:0];
        end
        if (cnt != '0 && cnt <= CNT_W'(ROWS)) begin
          below = rd_data;
        end
        if (cnt >= CNT_W'(2)) begin
          req.wr_en   = 1'b1;
          req.wr_addr = wr_cnt[ROW_W-1:0];
          req.wr_data = cur ^ above ^ below ^ (cur << 1) ^ (cur >> 1);
        end
        if (cnt != '0) begin
          above_next = cur;
          cur_next   = below;
        end
        if (cnt == CNT_W'(ROWS + 1)) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end

      ST_DONE: begin
        if (out_free) begin
          res.load     = 1'b1;
          res.cell_bit = 1'b0;
          state_next   = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule
